// ===== sv/fsvd_pkg.sv =====
// ----------------------------------------------------------------------------
// fsvd_pkg: shared types and constants for the form string value decoder
// Word layout, queue sizing, character codes, parse phases and register
// indexes used by the front end, the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fsvd_pkg;

   // tag window
   localparam int TAG_MAX_LEN   = 8;
   localparam int TAG_LEN_W     = 4;
   localparam int TAG_IDX_W     = $clog2(TAG_MAX_LEN);

   // hex digits taken by one escape
   localparam int ESC_MAX_DIGITS = 2;

   // configuration register indexes
   localparam logic [1:0] CSR_TAG_BYTES  = 2'd0;
   localparam logic [1:0] CSR_TAG_LENGTH = 2'd1;
   localparam logic [1:0] CSR_CAPACITY   = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] HEX_ALPHA_OFS = 8'h41 - 8'd10;
   localparam logic [7:0] CASE_OFS      = 8'h61 - 8'h41;

   // parse phases
   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_DECODE = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;
   localparam logic [1:0] PH_MISS   = 2'd3;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      logic       found;
      logic       last;
   } word_type;

   // words produced by one accepted item, in order
   typedef struct packed {
      logic [1:0] n;
      word_type   w0;
      word_type   w1;
   } push_type;

   // hex digit check, either case
   function automatic logic is_hex(input logic [7:0] c);
      logic [7:0] u;
      u = (c >= 8'h61) ? c - CASE_OFS : c;
      return (c >= CHAR_ZERO && c <= CHAR_NINE) || (u >= CHAR_UP_A && u <= CHAR_UP_F);
   endfunction

   // hex digit value, valid only where is_hex holds
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] u;
      logic [7:0] v;
      u = (c >= 8'h61) ? c - CASE_OFS : c;
      v = (c <= CHAR_NINE) ? c - CHAR_ZERO : u - HEX_ALPHA_OFS;
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/fsvd_front.sv =====
// ----------------------------------------------------------------------------
// fsvd_front: input side of the form string value decoder
// Holds the configuration registers, slides the tag window over incoming
// characters, decodes the value and hands zero to two words per item on.
// ----------------------------------------------------------------------------
`default_nettype none

module fsvd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [7:0]          req_in_byte,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [63:0]         csr_data,
   input  wire logic                q_room,
   output fsvd_pkg::push_type       push
);
   import fsvd_pkg::*;

   logic [TAG_MAX_LEN-1:0][7:0] tag_ff;
   logic [TAG_LEN_W-1:0]        tag_len_ff;
   logic [7:0]                  cap_ff;

   logic [TAG_MAX_LEN-1:0][7:0] recent_ff, recent_in;
   logic [7:0]                  before_ff, before_in;
   logic [3:0]                  seen_ff, seen_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [1:0]                  pend_ff, pend_in;
   logic [3:0]                  esc_ff, esc_in;
   logic [7:0]                  cnt_ff, cnt_in;

   logic                        accept;
   logic [TAG_LEN_W-1:0]        len_lim;
   logic [TAG_LEN_W-1:0]        eff_len;
   logic [TAG_MAX_LEN-1:0][7:0] shift_w;
   logic [TAG_MAX_LEN-1:0]      byte_ok;
   logic                        win_match;
   logic [7:0]                  before_sel;
   logic [1:0]                  enter_ph;
   logic                        c_hex;
   logic [3:0]                  c_val;
   logic                        cont;
   logic                        flush_v;
   logic [7:0]                  flush_b;
   logic                        main_v;
   logic [7:0]                  main_b;
   logic                        main_st;
   logic                        main_fd;

   assign csr_ready = 1'b1;
   assign req_stall = !q_room;
   assign accept    = req_valid && q_room;

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff     <= '0;
         tag_len_ff <= TAG_LEN_W'(1);
         cap_ff     <= 8'hFF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TAG_BYTES:  tag_ff     <= csr_data;
            CSR_TAG_LENGTH: tag_len_ff <= csr_data[TAG_LEN_W-1:0];
            CSR_CAPACITY:   cap_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // effective tag length: clamp, then stop at the first zero byte
   assign len_lim = (tag_len_ff > TAG_LEN_W'(TAG_MAX_LEN)) ? TAG_LEN_W'(TAG_MAX_LEN)
                                                           : tag_len_ff;
   always_comb begin
      eff_len = len_lim;
      for (int i = TAG_MAX_LEN - 1; i >= 0; i--) begin
         if (TAG_LEN_W'(i) < len_lim && tag_ff[i] == 8'h00) eff_len = TAG_LEN_W'(i);
      end
   end

   // window after shifting in the current character
   assign shift_w = {req_in_byte, recent_ff[TAG_MAX_LEN-1:1]};

   // compare the newest eff_len window bytes against the tag
   always_comb begin
      logic [TAG_LEN_W-1:0] pos;
      for (int i = 0; i < TAG_MAX_LEN; i++) begin
         pos        = TAG_LEN_W'(TAG_MAX_LEN) - eff_len + TAG_LEN_W'(i);
         byte_ok[i] = (TAG_LEN_W'(i) >= eff_len) ||
                      (shift_w[pos[TAG_IDX_W-1:0]] == tag_ff[i]);
      end
   end
   assign win_match = &byte_ok;

   // character right before the match
   always_comb begin
      logic [TAG_LEN_W-1:0] bpos;
      bpos = TAG_LEN_W'(TAG_MAX_LEN - 1) - eff_len;
      if (eff_len < TAG_LEN_W'(TAG_MAX_LEN)) before_sel = shift_w[bpos[TAG_IDX_W-1:0]];
      else before_sel = recent_ff[0];
   end

   assign enter_ph = (cap_ff == 8'h00) ? PH_DONE : PH_DECODE;
   assign c_hex    = is_hex(req_in_byte);
   assign c_val    = hex_value(req_in_byte);

   // step the parser for one accepted word
   always_comb begin
      recent_in = recent_ff;
      before_in = before_ff;
      seen_in   = seen_ff;
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      esc_in    = esc_ff;
      cnt_in    = cnt_ff;
      cont      = 1'b1;
      flush_v   = 1'b0;
      flush_b   = 8'h00;
      main_v    = 1'b0;
      main_b    = 8'h00;
      main_st   = 1'b0;
      main_fd   = 1'b0;
      if (accept) begin
         // an empty tag matches at the list start
         if (phase_ff == PH_SEARCH && eff_len == '0) phase_in = enter_ph;
         if (req_kind) begin
            // end of list: flush an open escape, then report status
            if (pend_ff != 2'd0) begin
               flush_v = 1'b1;
               flush_b = (pend_ff == 2'd1) ? CHAR_PCT : {4'h0, esc_ff};
            end
            main_v    = 1'b1;
            main_st   = 1'b1;
            main_fd   = (phase_in == PH_DECODE) || (phase_in == PH_DONE);
            recent_in = '0;
            before_in = 8'h00;
            seen_in   = 4'd0;
            phase_in  = PH_SEARCH;
            pend_in   = 2'd0;
            esc_in    = 4'h0;
            cnt_in    = 8'h00;
         end else if (phase_in == PH_SEARCH) begin
            if (req_in_byte == 8'h00) begin
               phase_in = PH_MISS;
            end else begin
               before_in = recent_ff[0];
               recent_in = shift_w;
               if (seen_ff < 4'(TAG_MAX_LEN + 1)) seen_in = seen_ff + 4'd1;
               if (seen_in >= eff_len && win_match) begin
                  if (seen_in == eff_len || before_sel == CHAR_AMP) phase_in = enter_ph;
                  else phase_in = PH_MISS;
               end
            end
         end else if (phase_in == PH_DECODE) begin
            if (pend_ff != 2'd0) begin
               if (c_hex) begin
                  cont = 1'b0;
                  if (pend_ff < 2'(ESC_MAX_DIGITS)) begin
                     esc_in  = c_val;
                     pend_in = 2'd2;
                  end else begin
                     pend_in = 2'd0;
                     main_v  = 1'b1;
                     main_b  = {esc_ff, c_val};
                     cnt_in  = cnt_ff + 8'd1;
                     if (cnt_in >= cap_ff) phase_in = PH_DONE;
                  end
               end else begin
                  // lone escape: emit it and go on with this character unless the capacity is reached
                  flush_v = 1'b1;
                  flush_b = (pend_ff == 2'd1) ? CHAR_PCT : {4'h0, esc_ff};
                  pend_in = 2'd0;
                  cnt_in  = cnt_ff + 8'd1;
                  if (cnt_in >= cap_ff) begin
                     phase_in = PH_DONE;
                     cont     = 1'b0;
                  end
               end
            end
            if (cont) begin
               if (req_in_byte == 8'h00 || req_in_byte == CHAR_AMP || cnt_in >= cap_ff) begin
                  phase_in = PH_DONE;
               end else if (req_in_byte == CHAR_PCT) begin
                  pend_in = 2'd1;
                  esc_in  = 4'h0;
               end else begin
                  main_v = 1'b1;
                  main_b = (req_in_byte == CHAR_PLUS) ? CHAR_SPACE : req_in_byte;
                  cnt_in = cnt_in + 8'd1;
                  if (cnt_in >= cap_ff) phase_in = PH_DONE;
               end
            end
         end
      end
   end

   // advance parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         before_ff <= 8'h00;
         seen_ff   <= 4'd0;
         phase_ff  <= PH_SEARCH;
         pend_ff   <= 2'd0;
         esc_ff    <= 4'h0;
         cnt_ff    <= 8'h00;
      end else begin
         recent_ff <= recent_in;
         before_ff <= before_in;
         seen_ff   <= seen_in;
         phase_ff  <= phase_in;
         pend_ff   <= pend_in;
         esc_ff    <= esc_in;
         cnt_ff    <= cnt_in;
      end
   end

   // pack the words for the queue: flushed escape first
   always_comb begin
      word_type mw;
      word_type fw;
      mw.out_byte  = main_b;
      mw.is_status = main_st;
      mw.found     = main_fd;
      mw.last      = main_st;
      fw.out_byte  = flush_b;
      fw.is_status = 1'b0;
      fw.found     = 1'b0;
      fw.last      = 1'b0;
      push.n  = {1'b0, flush_v} + {1'b0, main_v};
      push.w0 = flush_v ? fw : mw;
      push.w1 = mw;
   end

`ifndef SYNTHESIS
   a_end_gives_status: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind |-> (push.n == 2'd1 && push.w0.is_status) ||
                             (push.n == 2'd2 && push.w1.is_status))
      else $error("end item did not close with a status word");
   a_status_is_final: assert property (@(posedge clock) disable iff (reset)
      push.n == 2'd2 |-> !push.w0.is_status)
      else $error("status word ahead of a decoded byte");
   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.n == 2'd0)
      else $error("words pushed without an accepted item");
`endif

endmodule

`default_nettype wire

// ===== sv/fsvd_queue.sv =====
// ----------------------------------------------------------------------------
// fsvd_queue: result queue and output side of the form string value decoder
// Takes up to two words a cycle from the front end and presents them one a cycle
// on the result channel while rsp_stall is low; reports room for a further two words.
// ----------------------------------------------------------------------------
`default_nettype none

module fsvd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fsvd_pkg::push_type  push,
   output logic                     q_room,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_is_status,
   output logic                     rsp_found,
   output logic                     rsp_last
);
   import fsvd_pkg::*;

   word_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;
   word_type            head;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = count_ff != '0;
   assign q_room    = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);

   // present the head word
   assign head          = mem_ff[rd_ptr_ff];
   assign rsp_out_byte  = head.out_byte;
   assign rsp_is_status = head.is_status;
   assign rsp_found     = head.found;
   assign rsp_last      = head.last;

   // advance pointers and fill level
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push.n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store incoming words
   always_ff @(posedge clock) begin
      if (push.n != 2'd0) mem_ff[wr_ptr_ff] <= push.w0;
      if (push.n == 2'd2) mem_ff[wr_ptr_ff + QPTR_W'(1)] <= push.w1;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill level beyond depth");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.n != 2'd0 |-> count_ff <= QCNT_W'(QUEUE_DEPTH - 2))
      else $error("push into a queue without room");
   a_stalled_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(head))
      else $error("stalled result word changed");
`endif

endmodule

`default_nettype wire

// ===== sv/form_string_value_decode_unit.sv =====
// ----------------------------------------------------------------------------
// form_string_value_decode_unit: streaming percent decoder for one form field
// Finds the configured tag at a field start and emits the decoded value
// bytes, then a status word per list.
// ----------------------------------------------------------------------------
// A word is written into the result queue when its item is accepted and is
// presented on rsp from there. One item per cycle while req_stall is low; an
// item that yields two words uses the single-word output port twice, and req
// stalls once the four-entry result queue holds more than two words.
// Reset clears parser state, the queue and the registers (tag 0, length 1,
// capacity 255); the block takes items from the first cycle after reset.
`default_nettype none

module form_string_value_decode_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_status,
   output logic             rsp_found,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import fsvd_pkg::*;

   push_type push;
   logic     q_room;

   // parse and decode
   fsvd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_in_byte (req_in_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_room      (q_room),
      .push        (push)
   );

   // queue and deliver words
   fsvd_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .q_room        (q_room),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_status (rsp_is_status),
      .rsp_found     (rsp_found),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
